@@ rtl/xs8_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// xs8_pkg
// Shared types, constants and lane arithmetic for the eight-lane xoshiro256+
// generator bank with splitmix64 seeding.
// ----------------------------------------------------------------------------
package xs8_pkg;

	localparam int LANES      = 8;
	localparam int WORDS      = 4;
	localparam int WORD_W     = 64;
	localparam int HALF_W     = WORD_W / 2;
	localparam int ROW_W      = WORDS * LANES * WORD_W;
	localparam int WPR        = WORDS * LANES;
	localparam int WIDX_W     = $clog2(WPR);
	localparam int SAMPLE_W   = 24;
	localparam int SAMPLE_LSB = 40;
	localparam int NSLOT      = 8;

	typedef logic [WORD_W-1:0]   word_t;
	typedef logic [ROW_W-1:0]    row_t;
	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [2:0]          lane_idx_t;

	typedef enum logic {
		OP_DRAW   = 1'b0,
		OP_RESEED = 1'b1
	} op_t;

	// splitmix64
	localparam word_t SM_GOLD = 64'h9e3779b97f4a7c15;
	localparam word_t SM_MUL1 = 64'hbf58476d1ce4e5b9;
	localparam word_t SM_MUL2 = 64'h94d049bb133111eb;
	localparam int    SM_SH1  = 30;
	localparam int    SM_SH2  = 27;
	localparam int    SM_SH3  = 31;

	// xoshiro256+
	localparam int XO_SHL = 17;
	localparam int XO_ROT = 45;

	// output slot -> lane
	localparam lane_idx_t SLOT_LANE [NSLOT] = '{
		3'd4, 3'd5, 3'd0, 3'd1, 3'd6, 3'd7, 3'd2, 3'd3
	};

	typedef struct packed {
		word_t w3;
		word_t w2;
		word_t w1;
		word_t w0;
	} lane_st_t;

	function automatic lane_st_t xs8_advance(lane_st_t s);
		word_t    a;
		word_t    b;
		word_t    c;
		word_t    d;
		word_t    t;
		lane_st_t r;
		a = s.w0;
		b = s.w1;
		c = s.w2;
		d = s.w3;
		t = b << XO_SHL;
		c = c ^ a;
		d = d ^ b;
		b = b ^ c;
		a = a ^ d;
		c = c ^ t;
		d = (d << XO_ROT) | (d >> (WORD_W - XO_ROT));
		r.w0 = a;
		r.w1 = b;
		r.w2 = c;
		r.w3 = d;
		return r;
	endfunction

	function automatic sample_t xs8_sample(lane_st_t s);
		word_t sum;
		sum = s.w0 + s.w3;
		return sum[SAMPLE_LSB +: SAMPLE_W];
	endfunction

endpackage
`default_nettype wire

@@ rtl/xs8_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// xs8 channel interfaces
// Valid/ready channels for commands, results and the seed register write.
// ----------------------------------------------------------------------------
interface xs8_cmd_if;
	import xs8_pkg::*;
	logic       valid;
	logic       ready;
	op_t        opcode;
	logic [5:0] thread;
	modport source (output valid, output opcode, output thread, input ready);
	modport sink   (input valid, input opcode, input thread, output ready);
endinterface

interface xs8_res_if;
	import xs8_pkg::*;
	logic    valid;
	logic    ready;
	sample_t value_0;
	sample_t value_1;
	sample_t value_2;
	sample_t value_3;
	sample_t value_4;
	sample_t value_5;
	sample_t value_6;
	sample_t value_7;
	modport source (output valid, output value_0, output value_1, output value_2,
		output value_3, output value_4, output value_5, output value_6,
		output value_7, input ready);
	modport sink   (input valid, input value_0, input value_1, input value_2,
		input value_3, input value_4, input value_5, input value_6,
		input value_7, output ready);
endinterface

interface xs8_cfg_if;
	import xs8_pkg::*;
	logic  valid;
	logic  ready;
	word_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/xs8_store.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// xs8_store
// Generator state memory: one row of 4 words x 8 lanes per thread, one write
// and one registered read port. Per-row valid bits make unwritten rows read
// as zero.
// ----------------------------------------------------------------------------
module xs8_store #(
	parameter int  THREAD_COUNT = 64,
	localparam int AW = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            rd_en,
	input  logic [AW-1:0]   rd_addr,
	output xs8_pkg::row_t   rd_row,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  xs8_pkg::row_t   wr_row
);
	import xs8_pkg::*;

	row_t                    mem [THREAD_COUNT];
	row_t                    rd_row_q;
	logic [THREAD_COUNT-1:0] vld_q;
	logic                    rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_row;
		end
		if (rd_en) begin
			rd_row_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_row = rd_vld_q ? rd_row_q : '0;

endmodule
`default_nettype wire

@@ rtl/xs8_seeder.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// xs8_seeder
// splitmix64 sequencer for reseed. One shared 32x32 multiplier builds each
// 64-bit product from partial products in successive states; words gather
// in a row buffer and each full row is written to the store.
// ----------------------------------------------------------------------------
module xs8_seeder #(
	parameter int  THREAD_COUNT = 64,
	localparam int AW = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  xs8_pkg::word_t  seed,
	output logic            busy,
	output logic            wr_en,
	output logic [AW-1:0]   wr_addr,
	output xs8_pkg::row_t   wr_row
);
	import xs8_pkg::*;

	localparam logic [AW-1:0]     LAST_ROW  = AW'(THREAD_COUNT - 1);
	localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(WPR - 1);

	typedef enum logic [3:0] {
		S_IDLE, S_MIX, S_M1A, S_M1B, S_M1C, S_SH27,
		S_M2A, S_M2B, S_M2C, S_FIN, S_WR
	} st_t;

	st_t               state_q;
	logic [WIDX_W-1:0] word_q;
	logic [AW-1:0]     row_cnt_q;
	word_t             x_q;
	word_t             z_q;
	word_t             acc_q;
	row_t              row_q;

	logic [HALF_W-1:0] mul_a;
	logic [HALF_W-1:0] mul_b;
	word_t             mul_p;
	word_t             mul_sh;
	word_t             x_nxt;

	always_comb begin
		mul_a = z_q[HALF_W-1:0];
		mul_b = SM_MUL1[HALF_W-1:0];
		unique case (state_q)
			S_M1B: mul_b = SM_MUL1[WORD_W-1:HALF_W];
			S_M1C: mul_a = z_q[WORD_W-1:HALF_W];
			S_M2A: mul_b = SM_MUL2[HALF_W-1:0];
			S_M2B: mul_b = SM_MUL2[WORD_W-1:HALF_W];
			S_M2C: begin
				mul_a = z_q[WORD_W-1:HALF_W];
				mul_b = SM_MUL2[HALF_W-1:0];
			end
			default: begin
			end
		endcase
	end

	assign mul_p  = WORD_W'(mul_a) * WORD_W'(mul_b);
	assign mul_sh = {mul_p[HALF_W-1:0], {HALF_W{1'b0}}};
	assign x_nxt  = x_q + SM_GOLD;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			word_q    <= '0;
			row_cnt_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q   <= S_MIX;
						word_q    <= '0;
						row_cnt_q <= '0;
					end
				end
				S_MIX:  state_q <= S_M1A;
				S_M1A:  state_q <= S_M1B;
				S_M1B:  state_q <= S_M1C;
				S_M1C:  state_q <= S_SH27;
				S_SH27: state_q <= S_M2A;
				S_M2A:  state_q <= S_M2B;
				S_M2B:  state_q <= S_M2C;
				S_M2C:  state_q <= S_FIN;
				S_FIN: begin
					word_q  <= word_q + 1'b1;
					state_q <= (word_q == LAST_WORD) ? S_WR : S_MIX;
				end
				S_WR: begin
					if (row_cnt_q == LAST_ROW) begin
						state_q <= S_IDLE;
					end else begin
						row_cnt_q <= row_cnt_q + 1'b1;
						state_q   <= S_MIX;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: x_q <= seed;
			S_MIX: begin
				x_q <= x_nxt;
				z_q <= x_nxt ^ (x_nxt >> SM_SH1);
			end
			S_M1A, S_M2A: acc_q <= mul_p;
			S_M1B, S_M1C, S_M2B, S_M2C: acc_q <= acc_q + mul_sh;
			S_SH27: z_q <= acc_q ^ (acc_q >> SM_SH2);
			S_FIN: row_q <= {acc_q ^ (acc_q >> SM_SH3), row_q[ROW_W-1:WORD_W]};
			default: begin
			end
		endcase
	end

	assign busy    = (state_q != S_IDLE);
	assign wr_en   = (state_q == S_WR);
	assign wr_addr = row_cnt_q;
	assign wr_row  = row_q;

endmodule
`default_nettype wire

@@ rtl/multi_thread_xoshiro256plus_8lane_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// multi_thread_xoshiro256plus_8lane_top
// Eight xoshiro256+ generators per thread held in one wide row memory;
// draws advance a thread's row by read-modify-write, reseed refills the
// memory from a splitmix64 sequence.
//
// channel  modport  payload                  notes
// cmd      sink     opcode, thread           draw or reseed
// res      source   value_0 .. value_7       one transaction per draw
// cfg      sink     data (64 bit seed)       always ready
//
// Draw: one per cycle while results are taken and no reseed runs; the memory is
// read at the accepting edge, then the update stage loads the output register and writes back.
// A draw following one for the same thread takes the updated row from the
// write-back register, not the memory.
// Reseed: each word steps through the seeder states on the shared 32x32
// multiplier, one row write per thread; cmd is held off meanwhile.
// Reset clears per-row valid bits, so no clearing pass is needed.
// A stalled result holds the update stage and with it cmd.
// ----------------------------------------------------------------------------
module multi_thread_xoshiro256plus_8lane_top #(
	parameter int THREAD_COUNT = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	xs8_cmd_if.sink      cmd,
	xs8_res_if.source    res,
	xs8_cfg_if.sink      cfg
);
	import xs8_pkg::*;

	localparam int         AW  = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;
	localparam logic [8:0] TC9 = 9'(THREAD_COUNT);

	word_t         seed_q;
	logic          cmd_acc;
	logic          draw_acc;
	logic          rs_start;
	logic [8:0]    thr_ext;
	logic [AW-1:0] cmd_addr;

	logic          vld_s1;
	logic [AW-1:0] addr_s1;
	logic          inr_s1;
	logic          byp_s1;
	logic          s1_fire;
	logic          draw_we;

	row_t          rd_row;
	row_t          wb_q;
	row_t          cur_row;
	row_t          nxt_row;
	sample_t       samples [LANES];

	logic          res_vld_q;
	sample_t       val_q [NSLOT];

	logic          sd_busy;
	logic          sd_we;
	logic [AW-1:0] sd_addr;
	row_t          sd_row;

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	row_t          wr_row;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (cfg.valid) begin
			seed_q <= cfg.data;
		end
	end

	assign s1_fire   = vld_s1 && (!res_vld_q || res.ready);
	assign cmd.ready = !sd_busy && (!vld_s1 || s1_fire);
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign draw_acc  = cmd_acc && (cmd.opcode == OP_DRAW);
	assign rs_start  = cmd_acc && (cmd.opcode == OP_RESEED);
	assign thr_ext   = 9'(cmd.thread);
	assign cmd_addr  = thr_ext[AW-1:0];
	assign draw_we   = s1_fire && inr_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (draw_acc) begin
			vld_s1 <= 1'b1;
		end else if (s1_fire) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (draw_acc) begin
			addr_s1 <= cmd_addr;
			inr_s1  <= (thr_ext < TC9);
			byp_s1  <= draw_we && (addr_s1 == cmd_addr);
		end
		if (s1_fire) begin
			wb_q <= nxt_row;
		end
	end

	assign cur_row = byp_s1 ? wb_q : rd_row;

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		lane_st_t ls;
		lane_st_t ns;
		assign ls.w0 = cur_row[(0 * LANES + g) * WORD_W +: WORD_W];
		assign ls.w1 = cur_row[(1 * LANES + g) * WORD_W +: WORD_W];
		assign ls.w2 = cur_row[(2 * LANES + g) * WORD_W +: WORD_W];
		assign ls.w3 = cur_row[(3 * LANES + g) * WORD_W +: WORD_W];
		assign ns    = xs8_advance(ls);
		assign nxt_row[(0 * LANES + g) * WORD_W +: WORD_W] = ns.w0;
		assign nxt_row[(1 * LANES + g) * WORD_W +: WORD_W] = ns.w1;
		assign nxt_row[(2 * LANES + g) * WORD_W +: WORD_W] = ns.w2;
		assign nxt_row[(3 * LANES + g) * WORD_W +: WORD_W] = ns.w3;
		assign samples[g] = xs8_sample(ls);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (s1_fire) begin
			res_vld_q <= 1'b1;
		end else if (res.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			for (int i = 0; i < NSLOT; i++) begin
				val_q[i] <= inr_s1 ? samples[SLOT_LANE[i]] : '0;
			end
		end
	end

	assign res.valid   = res_vld_q;
	assign res.value_0 = val_q[0];
	assign res.value_1 = val_q[1];
	assign res.value_2 = val_q[2];
	assign res.value_3 = val_q[3];
	assign res.value_4 = val_q[4];
	assign res.value_5 = val_q[5];
	assign res.value_6 = val_q[6];
	assign res.value_7 = val_q[7];

	// seeder rows and draw write-back never coincide
	assign wr_en   = sd_we || draw_we;
	assign wr_addr = sd_we ? sd_addr : addr_s1;
	assign wr_row  = sd_we ? sd_row : nxt_row;

	xs8_store #(
		.THREAD_COUNT (THREAD_COUNT)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (draw_acc),
		.rd_addr (cmd_addr),
		.rd_row  (rd_row),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_row  (wr_row)
	);

	xs8_seeder #(
		.THREAD_COUNT (THREAD_COUNT)
	) u_seeder (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (rs_start),
		.seed    (seed_q),
		.busy    (sd_busy),
		.wr_en   (sd_we),
		.wr_addr (sd_addr),
		.wr_row  (sd_row)
	);

`ifndef NO_ASSERTIONS
	a_wr_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(sd_we && draw_we))
		else $error("seeder row write collides with draw write-back");

	a_rs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rs_start |=> sd_busy)
		else $error("reseed transaction did not start the seeder");

	a_busy_drained: assert property (@(posedge clk) disable iff (!arst_n)
		sd_busy |-> !vld_s1)
		else $error("draw in update stage while reseeding");

	a_fire_res: assert property (@(posedge clk) disable iff (!arst_n)
		s1_fire |=> res_vld_q)
		else $error("update stage fired without loading a result");
`endif

endmodule
`default_nettype wire

@@ verif/multi_thread_xoshiro256plus_8lane_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_thread_xoshiro256plus_8lane_top_tb
// Self-checking bench for the eight-lane xoshiro256+ generator bank. A local
// copy of every thread's generator words is kept in step with the block:
// refilled from a splitmix64 sequence on reseed and advanced on each draw.
// Each result transaction is compared slot by slot with the oldest predicted
// sample set. Traffic covers unseeded draws, seed extremes, same-thread
// back-to-back draws, random phases under several seeds, a long result
// stall and a sender pause.
// ----------------------------------------------------------------------------
module multi_thread_xoshiro256plus_8lane_top_tb;
	import xs8_pkg::*;

	localparam int THREAD_COUNT   = 64;
	localparam int RESEED_CYCLES  = THREAD_COUNT * 289;
	localparam int SETTLE_CYCLES  = 16;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 4 * RESEED_CYCLES + 2000;
	localparam int PHASE_ITEMS    = 80;
	localparam int MAX_REPORTS    = 10;

	localparam word_t MIX_GAMMA = 64'h9e3779b97f4a7c15;
	localparam word_t MIX_MUL_A = 64'hbf58476d1ce4e5b9;
	localparam word_t MIX_MUL_B = 64'h94d049bb133111eb;
	localparam int    LANE_OF_SLOT [NSLOT] = '{4, 5, 0, 1, 6, 7, 2, 3};

	typedef logic [NSLOT-1:0][SAMPLE_W-1:0] slot_row_t;

	logic clk;
	logic arst_n;

	xs8_cmd_if cmd_if ();
	xs8_res_if res_if ();
	xs8_cfg_if cfg_if ();

	multi_thread_xoshiro256plus_8lane_top #(
		.THREAD_COUNT(THREAD_COUNT)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_if),
		.res   (res_if),
		.cfg   (cfg_if)
	);

	word_t     seed_reg;
	word_t     gen_words [THREAD_COUNT][WORDS][LANES];
	slot_row_t draw_results [$];
	bit        reseed_busy;
	bit        idle_on;
	bit        hold_pending;
	int        mismatch_count;
	int        quiet_cycles;
	slot_row_t observed_row;
	slot_row_t wanted_row;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	function automatic void refill_banks();
		word_t x;
		word_t z;
		x = seed_reg;
		for (int th = 0; th < THREAD_COUNT; th++) begin
			for (int wd = 0; wd < WORDS; wd++) begin
				for (int ln = 0; ln < LANES; ln++) begin
					x = x + MIX_GAMMA;
					z = x;
					z = (z ^ (z >> 30)) * MIX_MUL_A;
					z = (z ^ (z >> 27)) * MIX_MUL_B;
					gen_words[th][wd][ln] = z ^ (z >> 31);
				end
			end
		end
	endfunction

	function automatic slot_row_t predict_draw(logic [5:0] th);
		word_t     a;
		word_t     b;
		word_t     c;
		word_t     d;
		word_t     t;
		word_t     sum;
		sample_t   lane_sample [LANES];
		slot_row_t row;
		row = '0;
		if (int'(th) >= THREAD_COUNT)
			return row;
		for (int ln = 0; ln < LANES; ln++) begin
			a = gen_words[th][0][ln];
			b = gen_words[th][1][ln];
			c = gen_words[th][2][ln];
			d = gen_words[th][3][ln];
			sum = a + d;
			lane_sample[ln] = sum[63:40];
			t = b << 17;
			c = c ^ a;
			d = d ^ b;
			b = b ^ c;
			a = a ^ d;
			c = c ^ t;
			d = (d << 45) | (d >> 19);
			gen_words[th][0][ln] = a;
			gen_words[th][1][ln] = b;
			gen_words[th][2][ln] = c;
			gen_words[th][3][ln] = d;
		end
		for (int s = 0; s < NSLOT; s++)
			row[s] = lane_sample[LANE_OF_SLOT[s]];
		return row;
	endfunction

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------
	task automatic send_cmd(op_t op, logic [5:0] th);
		if (idle_on && $urandom_range(99) < 30) begin
			cmd_if.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 30);
		end
		cmd_if.valid  <= 1'b1;
		cmd_if.opcode <= op;
		cmd_if.thread <= th;
		do @(posedge clk); while (!cmd_if.ready);
		if (op == OP_RESEED) begin
			refill_banks();
			reseed_busy = 1'b1;
		end else begin
			draw_results.push_back(predict_draw(th));
			reseed_busy = 1'b0;
		end
	endtask

	task automatic write_seed(word_t v);
		cfg_if.valid <= 1'b1;
		cfg_if.data  <= v;
		do @(posedge clk); while (!cfg_if.ready);
		seed_reg = v;
		cfg_if.valid <= 1'b0;
	endtask

	// a reseed gives no result, so its run time is waited out explicitly
	task automatic wait_idle();
		cmd_if.valid <= 1'b0;
		while (draw_results.size() != 0)
			@(posedge clk);
		repeat (reseed_busy ? RESEED_CYCLES + SETTLE_CYCLES : SETTLE_CYCLES)
			@(posedge clk);
		reseed_busy = 1'b0;
	endtask

	initial begin
		res_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				res_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				res_if.ready <= !idle_on || ($urandom_range(99) >= 30);
			end
		end
	end

	// ------------------------------------------------------------------
	// Result checker and watchdog
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready) begin
			observed_row = {res_if.value_7, res_if.value_6, res_if.value_5, res_if.value_4,
				res_if.value_3, res_if.value_2, res_if.value_1, res_if.value_0};
			if (draw_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("%0t: result transaction with none expected: %h", $realtime,
						observed_row);
			end else begin
				wanted_row = draw_results.pop_front();
				for (int s = 0; s < NSLOT; s++) begin
					if (observed_row[s] !== wanted_row[s]) begin
						mismatch_count++;
						if (mismatch_count <= MAX_REPORTS)
							$display("%0t: value_%0d expected %h, got %h", $realtime, s,
								wanted_row[s], observed_row[s]);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) ||
				(cfg_if.valid && cfg_if.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $realtime, quiet_cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_unseeded_draws();
		send_cmd(OP_DRAW, 6'd0);
		send_cmd(OP_DRAW, 6'd63);
		send_cmd(OP_DRAW, 6'd0);
		wait_idle();
	endtask

	task automatic test_seed_extremes();
		word_t seeds [2];
		seeds = '{64'h0, 64'hffff_ffff_ffff_ffff};
		foreach (seeds[i]) begin
			write_seed(seeds[i]);
			send_cmd(OP_RESEED, 6'h2a);
			send_cmd(OP_DRAW, 6'd0);
			send_cmd(OP_DRAW, 6'd63);
			send_cmd(OP_DRAW, 6'd0);
			send_cmd(OP_DRAW, 6'd0);
			send_cmd(OP_DRAW, 6'd31);
			wait_idle();
		end
	endtask

	task automatic test_same_thread_run();
		logic [5:0] order [8];
		order = '{6'd5, 6'd5, 6'd5, 6'd9, 6'd5, 6'd9, 6'd9, 6'd63};
		idle_on = 1'b0;
		foreach (order[i])
			send_cmd(OP_DRAW, order[i]);
		wait_idle();
		idle_on = 1'b1;
	endtask

	task automatic test_random_traffic();
		logic [5:0] th;
		logic [5:0] last_th;
		last_th = '0;
		for (int ph = 0; ph < 4; ph++) begin
			idle_on = (ph != 2);
			wait_idle();
			write_seed({$urandom, $urandom});
			send_cmd(OP_RESEED, 6'($urandom_range(63)));
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if ($urandom_range(99) == 0) begin
					send_cmd(OP_RESEED, 6'($urandom_range(63)));
				end else begin
					th = ($urandom_range(99) < 30) ? last_th : 6'($urandom_range(63));
					send_cmd(OP_DRAW, th);
					last_th = th;
				end
			end
		end
		wait_idle();
		idle_on = 1'b1;
	endtask

	task automatic test_result_stall();
		idle_on = 1'b0;
		hold_pending = 1'b1;
		for (int k = 0; k < 30; k++)
			send_cmd(OP_DRAW, 6'($urandom_range(63)));
		wait_idle();
		idle_on = 1'b1;
	endtask

	task automatic test_sender_pause();
		for (int k = 0; k < 10; k++)
			send_cmd(OP_DRAW, 6'($urandom_range(3)));
		wait_idle();
		for (int k = 0; k < 10; k++)
			send_cmd(OP_DRAW, 6'($urandom_range(3)));
		wait_idle();
	endtask

	initial begin
		arst_n         = 1'b0;
		cmd_if.valid   = 1'b0;
		cmd_if.opcode  = OP_DRAW;
		cmd_if.thread  = '0;
		cfg_if.valid   = 1'b0;
		cfg_if.data    = '0;
		seed_reg       = '0;
		reseed_busy    = 1'b0;
		idle_on        = 1'b1;
		hold_pending   = 1'b0;
		mismatch_count = 0;
		quiet_cycles   = 0;
		foreach (gen_words[th, wd, ln])
			gen_words[th][wd][ln] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_unseeded_draws();
		test_seed_extremes();
		test_same_thread_run();
		test_random_traffic();
		test_result_stall();
		test_sender_pause();
		wait_idle();

		if (draw_results.size() != 0)
			mismatch_count++;
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ files.f @@
rtl/xs8_pkg.sv
rtl/xs8_if.sv
rtl/xs8_store.sv
rtl/xs8_seeder.sv
rtl/multi_thread_xoshiro256plus_8lane_top.sv
verif/multi_thread_xoshiro256plus_8lane_top_tb.sv
